@@ rtl/bpfl_pkg.sv @@
// Shared types, codes and constants of the block pool free list allocator.
`default_nettype none
package bpfl_pkg;

	localparam int MAX_BLOCKS_DEF = 1024;

	// fixed field widths
	localparam int CMD_W     = 2;
	localparam int INDEX_W   = 10;
	localparam int ADDR_W    = 22;
	localparam int COUNT_W   = 11;
	localparam int STATUS_W  = 2;
	localparam int STRIDE_W  = 13;
	localparam int CHUNK_W   = 11;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 56;
	localparam int M_TUSER_W = 2;

	localparam logic [CHUNK_W-1:0]  DEFAULT_CHUNK = CHUNK_W'(64);
	localparam logic [STRIDE_W-1:0] MIN_STRIDE    = STRIDE_W'(8);
	localparam logic [STRIDE_W-1:0] STRIDE_MAX    = STRIDE_W'(8184);
	localparam logic [CFG_W-1:0]    BLOCK_BYTES_RST = CFG_W'(8);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_BYTES  = 1'b0,
		REG_CHUNK_BLOCKS = 1'b1
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_INIT  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EXHAUSTED = 2'd1,
		STAT_NULL_FREE = 2'd2,
		STAT_UNDERFLOW = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GROW,
		S_READ,
		S_POP,
		S_FIN
	} state_t;

	// max(bytes, 8) rounded up to a multiple of 8, saturated at 8184 to fit 13 bits
	function automatic logic [STRIDE_W-1:0] stride_of(input logic [CFG_W-1:0] bytes);
		logic [STRIDE_W:0] s;
		s = (bytes < MIN_STRIDE) ? (STRIDE_W+1)'(MIN_STRIDE) : (STRIDE_W+1)'(bytes);
		s = (s + (STRIDE_W+1)'(7)) & ~(STRIDE_W+1)'(7);
		return (s > (STRIDE_W+1)'(STRIDE_MAX)) ? STRIDE_MAX : s[STRIDE_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/block_pool_free_list_allocator.sv @@
// Fixed-size block allocator: LIFO free list of next links held in one block RAM.
//
// Usage: commands arrive on the s_axis beat (tuser = command: alloc, free, init, nop;
// tdata = block_present, block_index). Every command gives exactly one result beat
// on m_axis (tuser = status; tdata = granted index, address, in-use and grown counts).
// Registers block_bytes and chunk size are written through cfg_we/cfg_index/cfg_data
// and take effect at the next init command.
// Flow: free, init without growth, nop and an alloc that fails go through S_FIN to
// the output register; an alloc with a nonempty list pops the head in S_POP, and the
// head's next link comes from the link RAM read in the cycle after it is issued.
// A growth (alloc on an empty list, or init with a nonzero chunk size) writes one
// link per cycle in S_GROW, then an alloc reads the head in S_READ and pops in S_POP.
// One command is in flight at a time; s_axis_tready is high only when idle.
// The result sits in an output register, so the next command is taken while it
// waits; when the receiver stalls and the register is still full, the next result
// holds inside the block and no further command is taken.
// Reset: list empty, counts zero, chunk 64, stride 8; the link RAM is not cleared,
// every entry is written before it can be read.
`default_nettype none
module block_pool_free_list_allocator #(
	parameter int MAX_BLOCKS = bpfl_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bpfl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bpfl_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [0] block_present, [10:1] block_index, [15:11] zero
	input  wire logic [bpfl_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// [1:0] cmd
	input  wire logic [bpfl_pkg::S_TUSER_W-1:0]      s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [9:0] granted_index, [31:10] granted_address, [42:32] in_use_count,
	// [53:43] allocated_count, [55:54] zero
	output logic [bpfl_pkg::M_TDATA_W-1:0]           m_axis_tdata,
	// [1:0] status
	output logic [bpfl_pkg::M_TUSER_W-1:0]           m_axis_tuser
);
	import bpfl_pkg::*;

	localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LW  = $clog2(MAX_BLOCKS + 1);
	localparam int KW  = (LW > CHUNK_W) ? LW : CHUNK_W;
	localparam int XW  = (LW > INDEX_W) ? LW : INDEX_W;
	localparam int PW  = ((IW + STRIDE_W) > ADDR_W) ? (IW + STRIDE_W) : ADDR_W;
	localparam int OCW = (LW > COUNT_W) ? LW : COUNT_W;
	localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);

	// configuration
	logic [CFG_W-1:0]   block_bytes_q;
	logic [CHUNK_W-1:0] chunk_cfg_q;

	// allocator state
	state_t              state_q, state_d;
	logic [LW-1:0]       head_q;
	logic [LW-1:0]       in_use_q;
	logic [LW-1:0]       grown_q;
	logic [CHUNK_W-1:0]  chunk_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [LW-1:0]       grow_i_q, grow_start_q, grow_end_q;
	logic                grow_alloc_q;
	status_t             status_q;

	logic [LW-1:0] link_mem [MAX_BLOCKS];
	logic [LW-1:0] rd_data_q;

	// output register
	logic                m_valid_q;
	status_t             m_status_q;
	logic [INDEX_W-1:0]  m_index_q;
	logic [ADDR_W-1:0]   m_addr_q;
	logic [COUNT_W-1:0]  m_in_use_q;
	logic [COUNT_W-1:0]  m_grown_q;

	// control
	logic          s_acc, out_free, load;
	logic          rd_en, mem_we;
	logic [IW-1:0] mem_waddr;
	logic [LW-1:0] mem_wdata;

	cmd_t          in_cmd;
	logic          in_present;
	logic [XW-1:0] in_idx_x;
	logic          free_ok;
	logic          head_null;

	// growth sizing
	logic [LW-1:0] grow_base;
	logic [KW-1:0] chunk_k, room_k, count_k;
	logic [LW-1:0] grow_count, grow_end;
	logic          grow_last;

	// pop results
	logic [LW-1:0]  pop_next;
	logic [LW-1:0]  in_use_inc;
	logic [PW-1:0]  prod;
	logic [XW-1:0]  gidx_x;
	logic [OCW-1:0] in_use_x, grown_x;

	assign in_cmd     = cmd_t'(s_axis_tuser[CMD_W-1:0]);
	assign in_present = s_axis_tdata[0];
	assign in_idx_x   = XW'(s_axis_tdata[INDEX_W:1]);
	assign free_ok    = in_present && (in_idx_x < XW'(MAX_BLOCKS));
	assign head_null  = (head_q >= NULL_LINK);

	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	assign grow_base  = (in_cmd == CMD_INIT) ? '0 : grown_q;
	assign chunk_k    = (in_cmd == CMD_INIT) ? KW'(chunk_cfg_q) : KW'(chunk_q);
	assign room_k     = KW'(MAX_BLOCKS) - KW'(grow_base);
	assign count_k    = (chunk_k < room_k) ? chunk_k : room_k;
	assign grow_count = count_k[LW-1:0];
	assign grow_end   = grow_base + grow_count;
	assign grow_last  = ((grow_i_q + LW'(1)) == grow_end_q);

	assign pop_next   = (rd_data_q < NULL_LINK) ? rd_data_q : NULL_LINK;
	assign in_use_inc = (in_use_q < NULL_LINK) ? (in_use_q + LW'(1)) : in_use_q;
	assign prod       = PW'(head_q[IW-1:0]) * PW'(stride_q);
	assign gidx_x     = XW'(head_q[IW-1:0]);
	assign in_use_x   = OCW'((state_q == S_POP) ? in_use_inc : in_use_q);
	assign grown_x    = OCW'(grown_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					unique case (in_cmd)
						CMD_ALLOC: begin
							if (!head_null)
								state_d = S_POP;
							else if (grow_count != '0)
								state_d = S_GROW;
							else
								state_d = S_FIN;
						end
						CMD_INIT: state_d = (chunk_cfg_q != '0) ? S_GROW : S_FIN;
						CMD_FREE,
						CMD_NOP:  state_d = S_FIN;
					endcase
				end
			end
			S_GROW: begin
				if (grow_last)
					state_d = grow_alloc_q ? S_READ : S_FIN;
			end
			S_READ: state_d = S_POP;
			S_POP,
			S_FIN: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = in_idx_x[IW-1:0];
		mem_wdata     = head_q;
		load          = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				rd_en  = s_acc && (in_cmd == CMD_ALLOC) && !head_null;
				mem_we = s_acc && (in_cmd == CMD_FREE) && free_ok;
			end
			S_GROW: begin
				mem_we    = 1'b1;
				mem_waddr = grow_i_q[IW-1:0];
				// the first block of a chunk ends the list
				mem_wdata = (grow_i_q == grow_start_q) ? NULL_LINK : (grow_i_q - LW'(1));
			end
			S_READ: rd_en = 1'b1;
			S_POP,
			S_FIN: load = out_free;
			default: ;
		endcase
	end

	// link RAM, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			link_mem[mem_waddr] <= mem_wdata;
		if (rd_en)
			rd_data_q <= link_mem[head_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= BLOCK_BYTES_RST;
			chunk_cfg_q   <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BLOCK_BYTES:  block_bytes_q <= cfg_data;
				REG_CHUNK_BLOCKS: chunk_cfg_q   <= cfg_data[CHUNK_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= NULL_LINK;
			in_use_q     <= '0;
			grown_q      <= '0;
			chunk_q      <= DEFAULT_CHUNK;
			stride_q     <= MIN_STRIDE;
			grow_alloc_q <= 1'b0;
			status_q     <= STAT_OK;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						grow_alloc_q <= (in_cmd == CMD_ALLOC);
						unique case (in_cmd)
							CMD_ALLOC: begin
								status_q <= (head_null && grow_count == '0) ? STAT_EXHAUSTED
								                                            : STAT_OK;
							end
							CMD_FREE: begin
								if (!free_ok) begin
									status_q <= STAT_NULL_FREE;
								end else begin
									head_q <= in_idx_x[LW-1:0];
									if (in_use_q == '0) begin
										status_q <= STAT_UNDERFLOW;
									end else begin
										status_q <= STAT_OK;
										in_use_q <= in_use_q - LW'(1);
									end
								end
							end
							CMD_INIT: begin
								status_q <= STAT_OK;
								stride_q <= stride_of(block_bytes_q);
								chunk_q  <= (chunk_cfg_q != '0) ? chunk_cfg_q
								                                : DEFAULT_CHUNK;
								head_q   <= NULL_LINK;
								in_use_q <= '0;
								grown_q  <= '0;
							end
							CMD_NOP: status_q <= STAT_OK;
						endcase
					end
				end
				S_GROW: begin
					if (grow_last) begin
						head_q  <= grow_i_q;
						grown_q <= grow_end_q;
					end
				end
				S_POP: begin
					if (out_free) begin
						head_q   <= pop_next;
						in_use_q <= in_use_inc;
					end
				end
				S_READ,
				S_FIN: ;
				default: ;
			endcase
		end
	end

	// growth sweep registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_acc) begin
			grow_i_q     <= grow_base;
			grow_start_q <= grow_base;
			grow_end_q   <= grow_end;
		end else if (state_q == S_GROW) begin
			grow_i_q <= grow_i_q + LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (load)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_in_use_q <= in_use_x[COUNT_W-1:0];
			m_grown_q  <= grown_x[COUNT_W-1:0];
			if (state_q == S_POP) begin
				m_status_q <= STAT_OK;
				m_index_q  <= gidx_x[INDEX_W-1:0];
				m_addr_q   <= prod[ADDR_W-1:0];
			end else begin
				m_status_q <= status_q;
				m_index_q  <= '0;
				m_addr_q   <= '0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = M_TUSER_W'(m_status_q);
	assign m_axis_tdata  = {2'b00, m_grown_q, m_in_use_q, m_addr_q, m_index_q};

endmodule
`default_nettype wire

@@ rtl/bpfl_check.sv @@
// Port-level assertions for the block pool free list allocator, bound to the top level.
`default_nettype none
module bpfl_check (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_axis_tvalid,
	input wire logic                               s_axis_tready,
	input wire logic                               m_axis_tvalid,
	input wire logic                               m_axis_tready,
	input wire logic [bpfl_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	input wire logic [bpfl_pkg::M_TUSER_W-1:0]     m_axis_tuser
);
	import bpfl_pkg::*;

	logic s_beat;
	assign s_beat = s_axis_tvalid && s_axis_tready;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// one command in flight
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat |=> !s_axis_tready)
		else $error("command taken while another is in flight");

	// failed alloc grants nothing
	a_exhausted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == M_TUSER_W'(STAT_EXHAUSTED))
			|-> m_axis_tdata[31:0] == '0)
		else $error("exhausted alloc with nonzero grant");

	// underflow leaves the in-use count at zero
	a_underflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == M_TUSER_W'(STAT_UNDERFLOW))
			|-> m_axis_tdata[42:32] == '0)
		else $error("underflow with nonzero in-use count");

endmodule

bind block_pool_free_list_allocator bpfl_check u_bpfl_check (.*);
`default_nettype wire
